// ----- sv/assert_macros.svh -----
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ----- sv/dps_pkg.sv -----
// Package: sizes, codes and types of the deadline poll scheduler
package dps_pkg;
    localparam int NUM_FLOWS   = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_DATA = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] K_POLL  = 2'd0;
    localparam logic [1:0] K_DATA  = 2'd1;
    localparam logic [1:0] K_STALE = 2'd2;
    localparam logic [1:0] K_OVF   = 2'd3;

    localparam logic [1:0] POL_ZERO = 2'd0;
    localparam logic [1:0] POL_DM   = 2'd1;
    localparam logic [1:0] POL_EDF  = 2'd2;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [32:0]   pri;
        logic [FW-1:0] flow;
    } t_entry;

    // queue operation broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry ent;
    } t_qop;

    typedef enum logic [2:0] {
        S_IDLE, S_TMO, S_SCAN, S_INS, S_SEND, S_EMIT, S_FIN
    } t_state;
endpackage

// ----- sv/dps_cell.sv -----
// One queue cell: holds an entry, shifts on insert and pop
module dps_cell import dps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qop   i_op,
    input  t_entry i_left,
    input  logic   i_left_ge,
    input  logic   i_left_valid,
    input  t_entry i_right,
    input  logic   i_right_valid,
    output t_entry o_ent,
    output logic   o_valid,
    output logic   o_ge
);
    t_entry r_ent;
    logic   r_valid;

    // this cell holds an entry with priority above the new one
    assign o_ge    = r_valid && (r_ent.pri > i_op.ent.pri);
    assign o_ent   = r_ent;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.pop) begin
            r_valid <= i_right_valid;
            r_ent   <= i_right;
        end else if (i_op.ins) begin
            if (i_left_ge) begin
                r_ent   <= i_left;
                r_valid <= i_left_valid;
            end else if (o_ge || (!r_valid && i_left_valid)) begin
                r_ent   <= i_op.ent;
                r_valid <= 1'b1;
            end
        end
    end
endmodule

// ----- sv/dps_queue.sv -----
// Sorted priority queue as a row of cells
module dps_queue import dps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qop   i_op,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);
    t_entry ent [QUEUE_DEPTH+1];
    logic   vld [QUEUE_DEPTH+1];
    logic   ge  [QUEUE_DEPTH];

    assign ent[QUEUE_DEPTH] = '0;
    assign vld[QUEUE_DEPTH] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry le;
        logic   lg, lv;
        if (g == 0) begin : g_first
            assign le = '0;
            assign lg = 1'b0;
            assign lv = 1'b1;
        end else begin : g_rest
            assign le = ent[g-1];
            assign lg = ge[g-1];
            assign lv = vld[g-1];
        end
        dps_cell u_cell (
            .i_clk, .i_rst_n, .i_op,
            .i_left(le), .i_left_ge(lg), .i_left_valid(lv),
            .i_right(ent[g+1]), .i_right_valid(vld[g+1]),
            .o_ent(ent[g]), .o_valid(vld[g]), .o_ge(ge[g])
        );
    end

    assign o_head  = ent[0];
    assign o_empty = !vld[0];
    assign o_full  = vld[QUEUE_DEPTH-1];
endmodule

// ----- sv/deadline_poll_scheduler.sv -----
// Top level: flow table, release scan, transaction control
// Channel | Dir | tdata                                          | tuser | tlast
// s_axis  | in  | flow_index, period, deadline, burst, resp_trx  | cmd   | last_frame
// m_axis  | out | out_flow, out_burst, out_trx, latency_us       | kind  | done_res
// cfg     | in  | index 0 sched_policy, index 1 trx_timeout_us   | -     | -
// A data beat emits a result and a matching frame then tries a send. A tick
// checks the timeout, which may free the link and try a send, then scans the
// flow table one entry per cycle while no flow is due; each due flow is queued
// and a send tried. A result is held until the next result or the item end
// sets done_res; a further result first releases it, then waits for tready.
// Synchronous active-low reset clears table valid bits, queue and counters.
module deadline_poll_scheduler import dps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: flow_index[2:0] period[34:3] deadline[66:35] burst[82:67]
    //        resp_trx[114:83], zero pad to 120
    input  logic [119:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,  // cmd
    input  logic         s_axis_tlast,  // last_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_flow[2:0] out_burst[18:3] out_trx[50:19] latency_us[82:51],
    //        zero pad to 88
    output logic [87:0]  m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast   // done_res
);
    logic [1:0]  r_policy;
    logic [31:0] r_tmo;
    logic [31:0] r_per [NUM_FLOWS];
    logic [31:0] r_dl  [NUM_FLOWS];
    logic [15:0] r_bu  [NUM_FLOWS];
    logic [31:0] r_nr  [NUM_FLOWS];
    logic [NUM_FLOWS-1:0] r_fv;
    logic [31:0] r_now, r_trx, r_sent, r_tat;
    logic        r_busy;
    t_state      r_st, n_st;
    logic [FW:0] r_f;
    logic        r_scan;     // send phase returns to scan
    logic        r_ovalid;
    logic        r_orel;     // held beat is visible on m_axis
    logic [1:0]  r_kind;
    logic [FW-1:0] r_oflow;
    logic [15:0] r_oburst;
    logic [31:0] r_otrx, r_olat;
    logic        r_olast;
    logic [31:0] r_rt;
    logic        r_last;

    t_qop   q_op;
    t_entry q_head;
    logic   q_full, q_empty;
    dps_queue u_q (.i_clk, .i_rst_n, .i_op(q_op), .o_head(q_head),
                   .o_full(q_full), .o_empty(q_empty));

    logic [FW-1:0] fi;
    logic          fdue, scan_end;
    logic [32:0]   pri;
    logic [FW-1:0] li;
    logic [31:0]   ld_per;
    assign fi = r_f[FW-1:0];
    assign scan_end = (r_f == (FW+1)'(NUM_FLOWS));
    assign fdue = !scan_end && r_fv[fi] && (r_nr[fi] == r_now);
    assign li = s_axis_tdata[FW-1:0];
    assign ld_per = (s_axis_tdata[34:3] == '0) ? 32'd1 : s_axis_tdata[34:3];

    always_comb begin
        case (r_policy)
            POL_DM:  pri = {1'b0, r_dl[fi]};
            POL_EDF: pri = {1'b0, r_dl[fi]} + {1'b0, r_now};
            default: pri = '0;
        endcase
    end

    logic acc, tmo_hit, stale, can_send, o_hold, wr_ok;
    assign s_axis_tready = (r_st == S_IDLE);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign tmo_hit  = r_busy && (r_now == r_tat);
    assign stale    = (r_rt != r_trx);
    assign can_send = !r_busy && !q_empty;
    assign o_hold   = r_ovalid && !r_orel;
    assign wr_ok    = !r_ovalid || (r_orel && m_axis_tready);

    logic          o_wr, o_rel, w_last;
    logic [1:0]    w_kind;
    logic [FW-1:0] w_flow;
    logic [15:0]   w_burst;
    logic [31:0]   w_trx, w_lat;

    // outputs: queue control and result writes
    always_comb begin
        o_wr = 1'b0;
        o_rel = 1'b0;
        w_last = 1'b0;
        w_kind = K_POLL;
        w_flow = '0;
        w_burst = '0;
        w_trx = '0;
        w_lat = '0;
        q_op.ins = 1'b0;
        q_op.pop = 1'b0;
        q_op.ent.pri = pri;
        q_op.ent.flow = fi;
        case (r_st)
            S_INS: begin
                if (!q_full) begin
                    q_op.ins = 1'b1;
                end else if (o_hold) begin
                    o_rel = 1'b1;
                end else if (wr_ok) begin
                    o_wr = 1'b1;
                    w_kind = K_OVF;
                    w_flow = fi;
                end
            end
            S_SEND: if (can_send) begin
                if (o_hold) begin
                    o_rel = 1'b1;
                end else if (wr_ok) begin
                    o_wr = 1'b1;
                    q_op.pop = 1'b1;
                    w_kind = K_POLL;
                    w_flow = q_head.flow;
                    w_burst = r_bu[q_head.flow];
                    w_trx = r_trx + 32'd1;
                end
            end
            S_EMIT: begin
                if (o_hold) begin
                    o_rel = 1'b1;
                end else if (wr_ok) begin
                    o_wr = 1'b1;
                    w_trx = r_rt;
                    if (stale) begin
                        w_kind = K_STALE;
                    end else begin
                        w_kind = K_DATA;
                        w_lat = r_now - r_sent;
                    end
                end
            end
            S_FIN: if (o_hold) begin
                o_rel = 1'b1;
                w_last = 1'b1;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (acc) begin
                if (s_axis_tuser == CMD_TICK) n_st = S_TMO;
                else if (s_axis_tuser == CMD_DATA) n_st = S_EMIT;
            end
            S_TMO:  n_st = tmo_hit ? S_SEND : S_SCAN;
            S_SCAN: n_st = scan_end ? S_FIN : (fdue ? S_INS : S_SCAN);
            S_INS:  if (q_op.ins || o_wr) n_st = S_SEND;
            S_SEND: if (!can_send || o_wr) n_st = r_scan ? S_SCAN : S_FIN;
            S_EMIT: if (o_wr) n_st = stale ? S_FIN : S_SEND;
            S_FIN:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_policy <= POL_DM; r_tmo <= 32'd1000;
            r_fv <= '0; r_now <= '0; r_trx <= '0; r_sent <= '0; r_tat <= '0;
            r_busy <= 1'b0; r_f <= '0; r_scan <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_POLICY) r_policy <= i_cfg_data[1:0];
                else r_tmo <= i_cfg_data;
            end
            case (r_st)
                S_IDLE: if (acc) begin
                    r_rt   <= s_axis_tdata[114:83];
                    r_last <= s_axis_tlast;
                    r_f    <= '0;
                    r_scan <= (s_axis_tuser == CMD_TICK);
                    if (s_axis_tuser == CMD_TICK) r_now <= r_now + 32'd1;
                    if (s_axis_tuser == CMD_LOAD
                        && {1'b0, li} < (FW+1)'(NUM_FLOWS)) begin
                        r_per[li] <= ld_per;
                        r_dl[li] <= s_axis_tdata[66:35];
                        r_bu[li] <= s_axis_tdata[82:67];
                        r_fv[li] <= 1'b1;
                        r_nr[li] <= r_now + ld_per;
                    end
                end
                S_TMO: if (tmo_hit) r_busy <= 1'b0;
                S_SCAN: if (fdue) r_nr[fi] <= r_nr[fi] + r_per[fi];
                        else if (!scan_end) r_f <= r_f + (FW+1)'(1);
                S_INS: if (q_op.ins || o_wr) r_f <= r_f + (FW+1)'(1);
                S_SEND: if (o_wr) begin
                    r_busy <= 1'b1;
                    r_trx <= r_trx + 32'd1;
                    r_sent <= r_now;
                    r_tat <= r_now + ((r_tmo == '0) ? 32'd1 : r_tmo);
                end
                S_EMIT: if (o_wr && !stale && r_last) r_busy <= 1'b0;
                default: ;
            endcase
        end
    end

    // result register: a beat stays hidden until done_res is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_orel <= 1'b0;
            r_olast <= 1'b0;
        end else if (o_wr) begin
            r_ovalid <= 1'b1;
            r_orel <= 1'b0;
            r_kind <= w_kind;
            r_oflow <= w_flow;
            r_oburst <= w_burst;
            r_otrx <= w_trx;
            r_olat <= w_lat;
            r_olast <= 1'b0;
        end else if (o_rel) begin
            r_orel <= 1'b1;
            r_olast <= w_last;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid && r_orel;
    assign m_axis_tlast  = m_axis_tvalid && r_olast;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {5'd0, r_olat, r_otrx, r_oburst, r_oflow};
endmodule

// ----- sv/dps_checker.sv -----
// Port-level checker for the deadline poll scheduler
`include "assert_macros.svh"
module dps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_NEXT(a_data_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CHK_NEXT(a_user_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser))
    `CHK_NEXT(a_tlast_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast))
    `CHK_IMPL(a_last_only_valid, i_clk, i_rst_n, m_axis_tlast, m_axis_tvalid)
endmodule

bind deadline_poll_scheduler dps_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
